FILE: hw/rtl/integer_stack_machine_top_defines.svh
// ----------------------------------------------------------------------------
// Integer stack machine assertion macros
// Shared property wrappers for the stack machine RTL.
// ----------------------------------------------------------------------------
`ifndef INTEGER_STACK_MACHINE_TOP_DEFINES_SVH
`define INTEGER_STACK_MACHINE_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ISM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ISM_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/ism_pkg.sv
// ----------------------------------------------------------------------------
// Integer stack machine package
// Types, codes and helper functions shared by the stack machine modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ism_pkg;

   localparam int unsigned STACK_DEPTH_DEF = 1024;
   localparam logic [30:0] LIMIT_RESET     = 31'd1000000000;

   typedef enum logic [3:0] {
      OP_PUSH = 4'd0,
      OP_POP  = 4'd1,
      OP_NEG  = 4'd2,
      OP_DUP  = 4'd3,
      OP_SWAP = 4'd4,
      OP_ADD  = 4'd5,
      OP_SUB  = 4'd6,
      OP_MUL  = 4'd7,
      OP_DIV  = 4'd8,
      OP_MOD  = 4'd9
   } opcode_type;

   typedef enum logic [3:0] {
      K_PUSH, K_POP, K_NEG, K_DUP, K_SWAP, K_ADD, K_SUB, K_MUL, K_DIV, K_MOD, K_BAD
   } kind_type;

   typedef enum logic [2:0] {
      BK_IDLE, BK_RD_B, BK_RD_A, BK_EXEC, BK_DIV, BK_CHECK, BK_SWAP2, BK_DONE
   } back_state_type;

   typedef enum logic {
      REG_MAG_LIMIT = 1'b0
   } reg_index_type;

   typedef struct packed {
      logic [3:0]         opcode;
      logic signed [31:0] immediate;
      logic               first_instruction;
      logic               last_instruction;
   } req_type;

   typedef struct packed {
      logic signed [30:0] result_value;
      logic               status;
   } rsp_type;

   // Decoded instruction as it sits in the queue between front and back.
   typedef struct packed {
      kind_type           kind;
      logic [1:0]         needs;
      logic               grows;
      logic signed [31:0] imm;
      logic               first;
      logic               last;
   } cmd_type;

   function automatic logic over_limit(input logic signed [63:0] v,
                                       input logic [30:0] lim);
      logic signed [63:0] limw;
      limw = $signed({33'd0, lim});
      return (v > limw) || (v < -limw);
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ism_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ism_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/ism_div.sv
// ----------------------------------------------------------------------------
// Integer stack machine divider
// Radix-2 restoring signed divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ism_div (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [31:0] dividend,
   input  wire logic signed [31:0] divisor,
   output logic                    done,
   output logic signed [31:0]      quotient,
   output logic signed [31:0]      remainder
);

   localparam int unsigned STEPS = 32;
   localparam int unsigned CW    = $clog2(STEPS + 1);

   logic [CW-1:0] cnt_ff, cnt_in;
   logic          done_ff, done_in;
   logic [31:0]   quo_ff, quo_in;
   logic [31:0]   rem_ff, rem_in;
   logic [31:0]   dvs_ff, dvs_in;
   logic          negq_ff, negq_in;
   logic          negr_ff, negr_in;
   logic [32:0]   rem_shift;
   logic [33:0]   diff;

   always_comb begin
      cnt_in    = cnt_ff;
      done_in   = 1'b0;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      negq_in   = negq_ff;
      negr_in   = negr_ff;
      rem_shift = {rem_ff, quo_ff[31]};
      diff      = {1'b0, rem_shift} - {2'b00, dvs_ff};
      if (start) begin
         quo_in  = dividend[31] ? 32'(-dividend) : 32'(dividend);
         dvs_in  = divisor[31] ? 32'(-divisor) : 32'(divisor);
         rem_in  = '0;
         negq_in = dividend[31] ^ divisor[31];
         negr_in = dividend[31];
         cnt_in  = CW'(STEPS);
      end else if (cnt_ff != '0) begin
         if (!diff[33]) begin
            rem_in = diff[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = rem_shift[31:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in  = cnt_ff - CW'(1);
         done_in = (cnt_ff == CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      negq_ff <= negq_in;
      negr_ff <= negr_in;
   end

   assign done      = done_ff;
   assign quotient  = negq_ff ? -$signed(quo_ff) : $signed(quo_ff);
   assign remainder = negr_ff ? -$signed(rem_ff) : $signed(rem_ff);

endmodule

`default_nettype wire

FILE: hw/rtl/ism_front.sv
// ----------------------------------------------------------------------------
// Integer stack machine front end
// Accepts instructions and classifies them by operand needs and stack growth.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ism_front (
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire ism_pkg::req_type req_payload,
   input  wire logic             q_full,
   output logic                  q_push,
   output ism_pkg::cmd_type      q_data
);

   always_comb begin
      q_data.imm   = req_payload.immediate;
      q_data.first = req_payload.first_instruction;
      q_data.last  = req_payload.last_instruction;
      q_data.needs = 2'd0;
      q_data.grows = 1'b0;
      unique case (req_payload.opcode)
         ism_pkg::OP_PUSH: begin
            q_data.kind  = ism_pkg::K_PUSH;
            q_data.grows = 1'b1;
         end
         ism_pkg::OP_POP: begin
            q_data.kind  = ism_pkg::K_POP;
            q_data.needs = 2'd1;
         end
         ism_pkg::OP_NEG: begin
            q_data.kind  = ism_pkg::K_NEG;
            q_data.needs = 2'd1;
         end
         ism_pkg::OP_DUP: begin
            q_data.kind  = ism_pkg::K_DUP;
            q_data.needs = 2'd1;
            q_data.grows = 1'b1;
         end
         ism_pkg::OP_SWAP: begin
            q_data.kind  = ism_pkg::K_SWAP;
            q_data.needs = 2'd2;
         end
         ism_pkg::OP_ADD: begin
            q_data.kind  = ism_pkg::K_ADD;
            q_data.needs = 2'd2;
         end
         ism_pkg::OP_SUB: begin
            q_data.kind  = ism_pkg::K_SUB;
            q_data.needs = 2'd2;
         end
         ism_pkg::OP_MUL: begin
            q_data.kind  = ism_pkg::K_MUL;
            q_data.needs = 2'd2;
         end
         ism_pkg::OP_DIV: begin
            q_data.kind  = ism_pkg::K_DIV;
            q_data.needs = 2'd2;
         end
         ism_pkg::OP_MOD: begin
            q_data.kind  = ism_pkg::K_MOD;
            q_data.needs = 2'd2;
         end
         default: begin
            q_data.kind = ism_pkg::K_BAD;
         end
      endcase
   end

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

endmodule

`default_nettype wire

FILE: hw/rtl/ism_queue.sv
// ----------------------------------------------------------------------------
// Integer stack machine command queue
// Two-entry queue of decoded instructions between front and back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ism_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire ism_pkg::cmd_type push_data,
   input  wire logic             pop,
   output logic                  full,
   output logic                  empty,
   output ism_pkg::cmd_type      head
);

   ism_pkg::cmd_type slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign head  = slot_ff[rd_ptr_ff];

endmodule

`default_nettype wire

FILE: hw/rtl/ism_back.sv
// ----------------------------------------------------------------------------
// Integer stack machine back end
// Executes queued instructions on the stack memory and builds program results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "integer_stack_machine_top_defines.svh"

module ism_back #(
   parameter int unsigned STACK_DEPTH = ism_pkg::STACK_DEPTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             q_empty,
   input  wire ism_pkg::cmd_type q_head,
   output logic                  q_pop,
   input  wire logic [30:0]      limit,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output ism_pkg::rsp_type      rsp_payload
);

   localparam int unsigned AW = $clog2(STACK_DEPTH);
   localparam int unsigned DW = $clog2(STACK_DEPTH + 1);

   ism_pkg::back_state_type state_ff, state_in;
   ism_pkg::cmd_type        cmd_ff, cmd_in;
   logic [DW-1:0]           depth_ff, depth_in;
   logic                    err_ff, err_in;
   logic signed [31:0]      a_ff, a_in;
   logic signed [31:0]      b_ff, b_in;
   logic signed [63:0]      r_ff, r_in;
   logic signed [31:0]      bottom_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   ism_pkg::rsp_type        rsp_ff, rsp_in;

   logic [DW-1:0]      depth_eff;
   logic               err_eff;
   logic [DW-1:0]      dm1, dm2, em1;
   logic               we;
   logic [DW-1:0]      waddr_w, raddr_w;
   logic [31:0]        wdata;
   logic [31:0]        rdata;
   logic               div_start;
   logic               div_done;
   logic signed [31:0] div_q, div_r;
   logic signed [63:0] prod;
   logic               rsp_load;
   logic               bad;

   assign dm1       = depth_ff - DW'(1);
   assign dm2       = depth_ff - DW'(2);
   assign depth_eff = q_head.first ? '0 : depth_ff;
   assign err_eff   = q_head.first ? 1'b0 : err_ff;
   assign em1       = depth_eff - DW'(1);
   assign prod      = a_ff * b_ff;

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      depth_in  = depth_ff;
      err_in    = err_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      r_in      = r_ff;
      we        = 1'b0;
      waddr_w   = '0;
      wdata     = '0;
      raddr_w   = '0;
      q_pop     = 1'b0;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ism_pkg::BK_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               cmd_in   = q_head;
               depth_in = depth_eff;
               err_in   = err_eff;
               state_in = ism_pkg::BK_DONE;
               if (!err_eff) begin
                  case (q_head.kind)
                     ism_pkg::K_PUSH: begin
                        if (ism_pkg::over_limit(64'(q_head.imm), limit) ||
                            depth_eff == DW'(STACK_DEPTH)) begin
                           err_in = 1'b1;
                        end else begin
                           we       = 1'b1;
                           waddr_w  = depth_eff;
                           wdata    = q_head.imm;
                           depth_in = depth_eff + DW'(1);
                        end
                     end
                     ism_pkg::K_POP: begin
                        if (depth_eff == '0) begin
                           err_in = 1'b1;
                        end else begin
                           depth_in = em1;
                        end
                     end
                     ism_pkg::K_BAD: begin
                        err_in = 1'b1;
                     end
                     default: begin
                        if (depth_eff < DW'(q_head.needs) ||
                            (q_head.grows && depth_eff == DW'(STACK_DEPTH))) begin
                           err_in = 1'b1;
                        end else begin
                           raddr_w  = em1;
                           state_in = ism_pkg::BK_RD_B;
                        end
                     end
                  endcase
               end
            end
         end
         ism_pkg::BK_RD_B: begin
            raddr_w  = dm2;
            state_in = (cmd_ff.needs == 2'd2) ? ism_pkg::BK_RD_A : ism_pkg::BK_EXEC;
         end
         ism_pkg::BK_RD_A: begin
            b_in     = rdata;
            a_in     = rdata;
            state_in = ism_pkg::BK_EXEC;
         end
         ism_pkg::BK_EXEC: begin
            state_in = ism_pkg::BK_CHECK;
            case (cmd_ff.kind) inside
               ism_pkg::K_NEG: r_in = -64'(b_ff);
               ism_pkg::K_DUP: begin
                  we       = 1'b1;
                  waddr_w  = depth_ff;
                  wdata    = b_ff;
                  depth_in = depth_ff + DW'(1);
                  state_in = ism_pkg::BK_DONE;
               end
               ism_pkg::K_SWAP: begin
                  we       = 1'b1;
                  waddr_w  = dm1;
                  wdata    = a_ff;
                  state_in = ism_pkg::BK_SWAP2;
               end
               ism_pkg::K_ADD: r_in = 64'(a_ff) + 64'(b_ff);
               ism_pkg::K_SUB: r_in = 64'(a_ff) - 64'(b_ff);
               ism_pkg::K_MUL: r_in = prod;
               ism_pkg::K_DIV, ism_pkg::K_MOD: begin
                  if (b_ff == '0) begin
                     err_in   = 1'b1;
                     state_in = ism_pkg::BK_DONE;
                  end else begin
                     div_start = 1'b1;
                     state_in  = ism_pkg::BK_DIV;
                  end
               end
               default: state_in = ism_pkg::BK_DONE;
            endcase
         end
         ism_pkg::BK_DIV: begin
            if (div_done) begin
               r_in     = (cmd_ff.kind == ism_pkg::K_DIV) ? 64'(div_q) : 64'(div_r);
               state_in = ism_pkg::BK_CHECK;
            end
         end
         ism_pkg::BK_CHECK: begin
            state_in = ism_pkg::BK_DONE;
            if (ism_pkg::over_limit(r_ff, limit)) begin
               err_in = 1'b1;
            end else if (cmd_ff.kind == ism_pkg::K_NEG) begin
               we      = 1'b1;
               waddr_w = dm1;
               wdata   = r_ff[31:0];
            end else begin
               we       = 1'b1;
               waddr_w  = dm2;
               wdata    = r_ff[31:0];
               depth_in = dm1;
            end
         end
         ism_pkg::BK_SWAP2: begin
            we       = 1'b1;
            waddr_w  = dm2;
            wdata    = b_ff;
            state_in = ism_pkg::BK_DONE;
         end
         ism_pkg::BK_DONE: begin
            if (!cmd_ff.last) begin
               state_in = ism_pkg::BK_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ism_pkg::BK_IDLE;
            end
         end
         default: state_in = ism_pkg::BK_IDLE;
      endcase
      // The first read returns the top of stack whatever follows.
      if (state_ff == ism_pkg::BK_RD_B) begin
         b_in = rdata;
      end
      if (state_ff == ism_pkg::BK_RD_A) begin
         b_in = b_ff;
      end
   end

   // A final value must also fit the narrower signed result field.
   always_comb begin
      bad = err_ff || depth_ff != DW'(1) || (bottom_ff[31] != bottom_ff[30]);
      rsp_in.status       = bad;
      rsp_in.result_value = bad ? '0 : bottom_ff[30:0];
      rsp_valid_in        = rsp_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ism_pkg::BK_IDLE;
         depth_ff     <= '0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff <= cmd_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      r_ff   <= r_in;
      // Entry zero is mirrored so the program result needs no memory read.
      if (we && waddr_w == '0) begin
         bottom_ff <= wdata;
      end
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   ism_ram #(
      .WIDTH (32),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock (clock),
      .we    (we),
      .waddr (waddr_w[AW-1:0]),
      .wdata (wdata),
      .raddr (raddr_w[AW-1:0]),
      .rdata (rdata)
   );

   ism_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (a_ff),
      .divisor   (b_ff),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `ISM_ASSERT_IMP(a_depth_bound, clock, reset, 1'b1, depth_ff <= DW'(STACK_DEPTH), "stack depth beyond capacity")
   `ISM_ASSERT_IMP(a_div_nonzero, clock, reset, div_start, b_ff != '0, "divider started with zero divisor")
   `ISM_ASSERT_NXT(a_write_clean, clock, reset, we, !err_ff, "stack written by a failing instruction")

endmodule

`default_nettype wire

FILE: hw/rtl/integer_stack_machine_top.sv
// Integer stack machine: one instruction per request transaction, one result per program on the
// response channel. Decoded instructions wait in a two-entry queue, so requests keep flowing
// while the back end executes. In the back end, push, pop and any instruction rejected at decode
// go from idle straight to done. Dup reads the top of stack and writes its copy; negate, swap,
// add, sub and mul read operands, execute, then check or write back. Div and mod wait for the
// radix-2 divider that produces one quotient bit per cycle; a zero divisor ends the instruction
// without starting it. The response of the last instruction of a program is registered. The
// back end waits while an earlier response is still held. No clearing pass runs after reset.
// ----------------------------------------------------------------------------
// Integer stack machine top level
// Front end, command queue, back end and the magnitude limit register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module integer_stack_machine_top #(
   parameter int unsigned STACK_DEPTH = ism_pkg::STACK_DEPTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire ism_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output ism_pkg::rsp_type      rsp_payload,
   input  wire logic             csr_psel,
   input  wire logic             csr_penable,
   input  wire logic             csr_pwrite,
   input  wire logic [2:0]       csr_paddr,
   input  wire logic [31:0]      csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic [30:0]      limit_ff, limit_in;
   logic             hit;
   logic             q_full, q_empty, q_push, q_pop;
   ism_pkg::cmd_type q_data, q_head;

   assign hit        = (csr_paddr[2] == ism_pkg::REG_MAG_LIMIT);
   assign csr_pready = 1'b1;
   assign csr_prdata = hit ? {1'b0, limit_ff} : '0;

   always_comb begin
      limit_in = limit_ff;
      if (csr_psel && csr_penable && csr_pwrite && hit) begin
         limit_in = csr_pwdata[30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= ism_pkg::LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   ism_front u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_data      (q_data)
   );

   ism_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (q_head)
   );

   ism_back #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .limit       (limit_ff),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

FILE: dv/integer_stack_machine_top_tb.sv
// ----------------------------------------------------------------------------
// Integer stack machine testbench
// Drives instruction transactions and APB limit writes into the stack machine,
// predicts every program result with a behavioural stack and compares them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class program_scoreboard;
   localparam int unsigned DEPTH = 1024;
   logic signed [31:0] entries [DEPTH];
   int unsigned height;
   bit faulted;
   logic [30:0] limit;
   ism_pkg::rsp_type pending [$];
   int unsigned mismatches;
   int unsigned results_seen;
   int unsigned errors_seen;

   function new();
      height = 0;
      faulted = 0;
      limit = ism_pkg::LIMIT_RESET;
      mismatches = 0;
      results_seen = 0;
      errors_seen = 0;
   endfunction

   function bit beyond(longint v);
      longint lw;
      lw = longint'(limit);
      return (v > lw) || (v < -lw);
   endfunction

   // Returns 1 when the instruction raises the error flag.
   function bit run_op(ism_pkg::req_type rq);
      longint a, b, r;
      int unsigned d;
      logic signed [31:0] t;
      d = height;
      case (rq.opcode)
         ism_pkg::OP_PUSH: begin
            if (beyond(longint'(rq.immediate)) || d >= DEPTH) return 1;
            entries[d] = rq.immediate;
            height = d + 1;
         end
         ism_pkg::OP_POP: begin
            if (d == 0) return 1;
            height = d - 1;
         end
         ism_pkg::OP_NEG: begin
            if (d == 0) return 1;
            r = -longint'(entries[d-1]);
            if (beyond(r)) return 1;
            entries[d-1] = r[31:0];
         end
         ism_pkg::OP_DUP: begin
            if (d == 0 || d >= DEPTH) return 1;
            entries[d] = entries[d-1];
            height = d + 1;
         end
         ism_pkg::OP_SWAP: begin
            if (d < 2) return 1;
            t = entries[d-1];
            entries[d-1] = entries[d-2];
            entries[d-2] = t;
         end
         ism_pkg::OP_ADD, ism_pkg::OP_SUB, ism_pkg::OP_MUL,
         ism_pkg::OP_DIV, ism_pkg::OP_MOD: begin
            if (d < 2) return 1;
            a = longint'(entries[d-2]);
            b = longint'(entries[d-1]);
            if (rq.opcode == ism_pkg::OP_ADD) r = a + b;
            else if (rq.opcode == ism_pkg::OP_SUB) r = a - b;
            else if (rq.opcode == ism_pkg::OP_MUL) r = a * b;
            else begin
               if (b == 0) return 1;
               r = (rq.opcode == ism_pkg::OP_DIV) ? a / b : a % b;
            end
            if (beyond(r)) return 1;
            entries[d-2] = r[31:0];
            height = d - 1;
         end
         default: return 1;
      endcase
      return 0;
   endfunction

   function void note_instruction(ism_pkg::req_type rq);
      ism_pkg::rsp_type rs;
      longint v;
      bit bad;
      if (rq.first_instruction) begin
         height = 0;
         faulted = 0;
      end
      if (!faulted && run_op(rq)) faulted = 1;
      if (!rq.last_instruction) return;
      bad = faulted || height != 1;
      v = 0;
      if (!bad) begin
         v = longint'(entries[0]);
         if (v > 1073741823 || v < -1073741824) begin
            bad = 1;
            v = 0;
         end
      end
      rs.result_value = bad ? 31'sd0 : v[30:0];
      rs.status = bad;
      pending.insert(pending.size(), rs);
   endfunction

   task report(string what, longint want, longint got);
      mismatches++;
      $display("mismatch %s: expected %0d got %0d", what, want, got);
   endtask

   task check_result(ism_pkg::rsp_type got);
      ism_pkg::rsp_type want;
      results_seen++;
      if (got.status) errors_seen++;
      if (pending.size() == 0) begin
         report("unexpected result", 0, got.result_value);
         return;
      end
      want = pending.pop_front();
      if (got.result_value !== want.result_value)
         report("result_value", want.result_value, got.result_value);
      if (got.status !== want.status)
         report("status", want.status, got.status);
   endtask
endclass

module integer_stack_machine_top_tb;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   ism_pkg::req_type req_payload;
   logic rsp_valid;
   logic rsp_ready;
   ism_pkg::rsp_type rsp_payload;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [2:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   logic csr_pready;

   program_scoreboard board;
   longint cycle_count;
   bit quiet_tail;
   int unsigned programs_sent;
   int unsigned items_sent;

   localparam longint CYCLE_LIMIT = 2000000;

   integer_stack_machine_top dut (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("status: fail");
         $finish;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_valid && rsp_ready) board.check_result(rsp_payload);

   // Receiver stalls come in bursts; none in the closing part of the run.
   initial begin
      int unsigned n;
      rsp_ready = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         rsp_ready <= 1;
         n = $urandom_range(1, 20);
         repeat (n) @(negedge clock);
         if (!quiet_tail && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 0;
            n = $urandom_range(1, 10);
            repeat (n) @(negedge clock);
         end
      end
   end

   // Valid stays high after acceptance so that back-to-back transactions need
   // only one update; an idle burst or a drain lowers it.
   task automatic send_instruction(ism_pkg::opcode_type op, logic signed [31:0] imm,
                                   bit first, bit last);
      int unsigned gap;
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 10);
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_payload <= '{opcode: op, immediate: imm, first_instruction: first,
                       last_instruction: last};
      req_valid <= 1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_instruction(req_payload);
      items_sent++;
      if (last) programs_sent++;
      @(negedge clock);
   endtask

   task automatic send_raw(logic [3:0] code, logic signed [31:0] imm, bit first, bit last);
      send_instruction(ism_pkg::opcode_type'(code), imm, first, last);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
      // Instructions that produce no result may still be executing.
      repeat (200) @(negedge clock);
   endtask

   task automatic write_limit(logic [30:0] value);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_penable <= 0;
      csr_paddr <= 3'(4 * ism_pkg::REG_MAG_LIMIT);
      csr_pwdata <= {1'b0, value};
      @(negedge clock);
      csr_penable <= 1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      board.limit = value;
      @(negedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
   endtask

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 5))
         0: return $signed($urandom_range(0, 20)) - 10;
         1: return $signed($urandom_range(0, 2000)) - 1000;
         2: return $signed($urandom);
         3: return $signed($urandom_range(0, 200000)) - 100000;
         default: return $signed($urandom_range(0, 64000)) - 32000;
      endcase
   endfunction

   // One random program: mostly pushes and operations keeping enough operands, now and then any operation.
   task automatic random_program(int unsigned len);
      int unsigned depth;
      ism_pkg::opcode_type op;
      bit last;
      depth = 0;
      for (int unsigned i = 0; i < len; i++) begin
         last = (i == len - 1);
         if (depth < 2 || $urandom_range(0, 2) == 0) op = ism_pkg::OP_PUSH;
         else op = ism_pkg::opcode_type'($urandom_range(1, 9));
         if (!last && $urandom_range(0, 15) == 0)
            op = ism_pkg::opcode_type'($urandom_range(0, 9));
         send_instruction(op, pick_value(), i == 0, last);
         case (op)
            ism_pkg::OP_PUSH, ism_pkg::OP_DUP: depth++;
            ism_pkg::OP_POP: if (depth > 0) depth--;
            ism_pkg::OP_ADD, ism_pkg::OP_SUB, ism_pkg::OP_MUL,
            ism_pkg::OP_DIV, ism_pkg::OP_MOD: if (depth > 1) depth--;
            default: ;
         endcase
      end
   endtask

   initial begin
      int unsigned count, len;
      board = new();
      cycle_count = 0;
      quiet_tail = 0;
      programs_sent = 0;
      items_sent = 0;
      reset = 1;
      req_valid = 0;
      req_payload = '0;
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed: every operation, limits, zero divisor, underflow, bad codes.
      send_instruction(ism_pkg::OP_PUSH, 32'sd1000000000, 1, 0);
      send_instruction(ism_pkg::OP_NEG, 0, 0, 0);
      send_instruction(ism_pkg::OP_DUP, 0, 0, 0);
      send_instruction(ism_pkg::OP_SWAP, 0, 0, 0);
      send_instruction(ism_pkg::OP_ADD, 0, 0, 1);
      send_instruction(ism_pkg::OP_PUSH, 32'sd7, 1, 0);
      send_instruction(ism_pkg::OP_PUSH, -32'sd3, 0, 0);
      send_instruction(ism_pkg::OP_MOD, 0, 0, 1);
      send_instruction(ism_pkg::OP_PUSH, -32'sd7, 1, 0);
      send_instruction(ism_pkg::OP_PUSH, 32'sd2, 0, 0);
      send_instruction(ism_pkg::OP_DIV, 0, 0, 1);
      send_instruction(ism_pkg::OP_PUSH, 32'sd5, 1, 0);
      send_instruction(ism_pkg::OP_PUSH, 32'sd0, 0, 0);
      send_instruction(ism_pkg::OP_DIV, 0, 0, 1);
      send_instruction(ism_pkg::OP_POP, 0, 1, 1);
      send_instruction(ism_pkg::OP_PUSH, 32'sh80000000, 1, 1);
      send_instruction(ism_pkg::OP_PUSH, 32'sh7fffffff, 1, 1);
      send_instruction(ism_pkg::OP_PUSH, 32'sd40000, 1, 0);
      send_instruction(ism_pkg::OP_DUP, 0, 0, 0);
      send_instruction(ism_pkg::OP_MUL, 0, 0, 1);
      send_raw(4'd15, 0, 1, 1);
      send_raw(4'd10, 0, 1, 0);
      send_instruction(ism_pkg::OP_PUSH, 32'sd3, 1, 0);
      send_instruction(ism_pkg::OP_SUB, 0, 0, 1);
      send_instruction(ism_pkg::OP_PUSH, 32'sd9, 0, 1);
      drain();

      // Extreme limits: full range exposes the too-wide result case, zero
      // rejects everything but zero.
      write_limit(31'h7fffffff);
      send_instruction(ism_pkg::OP_PUSH, 32'sh7fffffff, 1, 0);
      send_instruction(ism_pkg::OP_PUSH, 32'sh80000000, 0, 0);
      send_instruction(ism_pkg::OP_POP, 0, 0, 1);
      send_instruction(ism_pkg::OP_PUSH, -32'sd2147483647, 1, 0);
      send_instruction(ism_pkg::OP_PUSH, -32'sd1, 0, 0);
      send_instruction(ism_pkg::OP_DIV, 0, 0, 1);
      drain();
      write_limit(31'd0);
      send_instruction(ism_pkg::OP_PUSH, 32'sd0, 1, 0);
      send_instruction(ism_pkg::OP_NEG, 0, 0, 1);
      send_instruction(ism_pkg::OP_PUSH, 32'sd1, 1, 1);
      drain();

      // Fill the stack to its full depth and overflow it by one.
      write_limit(31'd1000);
      send_instruction(ism_pkg::OP_PUSH, 32'sd1, 1, 0);
      for (int i = 1; i < 1024; i++) send_instruction(ism_pkg::OP_DUP, 0, 0, 0);
      send_instruction(ism_pkg::OP_PUSH, 32'sd1, 0, 1);
      drain();

      // Random programs under several limits; a missing first flag now and then.
      count = 0;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: write_limit(ism_pkg::LIMIT_RESET);
            1: write_limit(31'($urandom_range(1, 100000)));
            2: write_limit(31'h7fffffff);
            default: write_limit(31'($urandom_range(0, 2147483647)));
         endcase
         while (count < 210 * (phase + 1)) begin
            if (phase == 3 && count > 700) quiet_tail = 1;
            len = $urandom_range(1, 12);
            if ($urandom_range(0, 9) == 0) begin
               send_raw(4'($urandom), pick_value(), $urandom_range(0, 1),
                        $urandom_range(0, 1));
               len = 1;
            end else begin
               random_program(len);
            end
            count += len;
         end
         drain();
      end

      drain();
      $display("covered %0d instructions (%0d random) in %0d programs", items_sent, count,
               programs_sent);
      $display("checked %0d results, %0d of them with error status", board.results_seen,
               board.errors_seen);
      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule
